>>> design/ascii_integer_parser_macros.svh
// Assertion helpers for the ASCII integer parser.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define AIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent.
`define AIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define AIP_ASSERT(lbl, clk, rst, prop, msg)
`define AIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/aip_pkg.sv
package aip_pkg;

   // Character codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_F  = 8'h66;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;

   localparam logic [1:0] COUNT_MAX = 2'd3;

   // One input item
   typedef struct packed {
      logic [7:0] character;
      logic       last_char;
   } item_type;

   // Input register to parser
   typedef struct packed {
      logic     fire;
      item_type item;
   } issue_type;

   // One result item
   typedef struct packed {
      logic signed [63:0] value;
      logic               ok;
   } result_type;

   // Parser to output register
   typedef struct packed {
      logic       valid;
      result_type res;
   } res_msg_type;

   // Running parse state
   typedef struct packed {
      logic        seen_text;
      logic        pending_space;
      logic [1:0]  text_count;
      logic [7:0]  first_char;
      logic        second_is_x;
      logic        hex_stopped;
      logic        hex_any_digit;
      logic [31:0] hex_value;
      logic        bin_good;
      logic [63:0] bin_value;
      logic        dec_good;
      logic        dec_negative;
      logic [31:0] dec_value;
   } parse_state_type;

   localparam parse_state_type PARSE_CLEAR = '{
      seen_text:     1'b0,
      pending_space: 1'b0,
      text_count:    2'd0,
      first_char:    8'd0,
      second_is_x:   1'b0,
      hex_stopped:   1'b0,
      hex_any_digit: 1'b0,
      hex_value:     32'd0,
      bin_good:      1'b1,
      bin_value:     64'd0,
      dec_good:      1'b1,
      dec_negative:  1'b0,
      dec_value:     32'd0
   };

   // Hex digit decode: bit 4 flags a digit, bits 3:0 its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[CHAR_LO_A:CHAR_LO_F], [CHAR_UP_A:CHAR_UP_F]}) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   // Saturating text counter
   function automatic logic [1:0] count_inc(input logic [1:0] n);
      return (n == COUNT_MAX) ? COUNT_MAX : 2'(n + 2'd1);
   endfunction

endpackage

>>> design/aip_in_reg.sv
// Input register: holds one item until the parser can take it.
module aip_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  aip_pkg::item_type    req_item,
   input  logic                 out_free,
   output aip_pkg::issue_type   issue
);

   logic              vld_ff, vld_in;
   aip_pkg::item_type item_ff, item_in;
   logic              adv;

   // A non-last item always moves on; a last one needs a free result slot
   assign adv        = vld_ff && (!item_ff.last_char || out_free);
   assign req_tready = !vld_ff || adv;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (req_tready) begin
         vld_in  = req_tvalid;
         item_in = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign issue.fire = adv;
   assign issue.item = item_ff;

endmodule

>>> design/aip_parse_core.sv
// Parse state update and result selection, one item per cycle while items are issued.
module aip_parse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [0:0]           csr_data,
   input  aip_pkg::issue_type   issue,
   output aip_pkg::res_msg_type res_msg
);

   aip_pkg::parse_state_type st_ff, st_in, nx;
   logic        binary_flag_ff, binary_flag_in;
   logic [7:0]  c;
   logic [1:0]  pos;
   logic [4:0]  hd;
   logic [31:0] dec_neg;
   logic [63:0] val;
   logic        ok;

   assign c  = issue.item.character;
   assign hd = aip_pkg::hex_digit(c);

   // Feed the character (and any held interior space) to all readers
   always_comb begin
      nx  = st_ff;
      pos = st_ff.text_count;
      if (c == aip_pkg::CHAR_SPACE) begin
         if (st_ff.seen_text) begin
            nx.pending_space = 1'b1;
         end
      end else begin
         // Held space: a non-digit everywhere, ends hex digits
         if (st_ff.pending_space) begin
            nx.bin_good = 1'b0;
            nx.dec_good = 1'b0;
            if (pos == 2'd1) begin
               nx.second_is_x = 1'b0;
            end
            if (pos >= 2'd2) begin
               nx.hex_stopped = 1'b1;
            end
            pos              = aip_pkg::count_inc(pos);
            nx.pending_space = 1'b0;
         end
         if (pos == 2'd0) begin
            nx.first_char = c;
         end
         if (pos == 2'd1) begin
            nx.second_is_x = (c inside {aip_pkg::CHAR_LO_X, aip_pkg::CHAR_UP_X});
         end
         if (pos >= 2'd2 && !nx.hex_stopped) begin
            if (hd[4]) begin
               nx.hex_value     = {st_ff.hex_value[27:0], hd[3:0]};
               nx.hex_any_digit = 1'b1;
            end else begin
               nx.hex_stopped = 1'b1;
            end
         end
         // Binary reader
         if (c inside {aip_pkg::CHAR_ZERO, aip_pkg::CHAR_ONE}) begin
            nx.bin_value = {st_ff.bin_value[62:0], c[0]};
         end else begin
            nx.bin_good = 1'b0;
         end
         // Decimal reader: value * 10 + digit, wrapping
         if (c inside {[aip_pkg::CHAR_ZERO:aip_pkg::CHAR_NINE]}) begin
            nx.dec_value = {st_ff.dec_value[28:0], 3'b000}
                         + {st_ff.dec_value[30:0], 1'b0}
                         + {28'd0, c[3:0]};
         end else if ((c inside {aip_pkg::CHAR_PLUS, aip_pkg::CHAR_MINUS}) &&
                      pos == 2'd0) begin
            nx.dec_negative = (c == aip_pkg::CHAR_MINUS);
         end else begin
            nx.dec_good = 1'b0;
         end
         nx.text_count = aip_pkg::count_inc(pos);
         nx.seen_text  = 1'b1;
      end
   end

   // Pick the reader that applies to the finished text
   assign dec_neg = nx.dec_negative ? (32'd0 - nx.dec_value) : nx.dec_value;

   always_comb begin
      if (!nx.seen_text) begin
         ok  = 1'b0;
         val = 64'd0;
      end else if (nx.text_count == aip_pkg::COUNT_MAX &&
                   nx.first_char == aip_pkg::CHAR_ZERO && nx.second_is_x) begin
         ok  = nx.hex_any_digit;
         val = {32'd0, nx.hex_value};
      end else if (binary_flag_ff) begin
         ok  = nx.bin_good;
         val = nx.bin_value;
      end else begin
         ok  = nx.dec_good;
         val = {{32{dec_neg[31]}}, dec_neg};
      end
   end

   assign res_msg.valid     = issue.fire && issue.item.last_char;
   assign res_msg.res.ok    = ok;
   assign res_msg.res.value = ok ? val : 64'd0;

   // State advances per item; a last item clears it
   always_comb begin
      st_in = st_ff;
      if (issue.fire) begin
         st_in = issue.item.last_char ? aip_pkg::PARSE_CLEAR : nx;
      end
      binary_flag_in = csr_valid ? csr_data[0] : binary_flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff          <= aip_pkg::PARSE_CLEAR;
         binary_flag_ff <= 1'b0;
      end else begin
         st_ff          <= st_in;
         binary_flag_ff <= binary_flag_in;
      end
   end

endmodule

>>> design/aip_out_reg.sv
// Result register: holds one result until taken.
module aip_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  aip_pkg::res_msg_type res_msg,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output aip_pkg::result_type  rsp_res
);

   logic                vld_ff, vld_in;
   aip_pkg::result_type res_ff, res_in;

   assign out_free = !vld_ff || rsp_tready;

   always_comb begin
      vld_in = vld_ff;
      res_in = res_ff;
      if (out_free) begin
         vld_in = res_msg.valid;
         res_in = res_msg.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_res    = res_ff;

endmodule

>>> design/ascii_integer_parser.sv
// Channel | Direction | Payload
// req     | in        | tdata[7:0] character, tlast last_char
// rsp     | out       | tdata[63:0] value, tuser[0] ok
// csr     | in        | data[0] binary_flag
//
// One character per cycle unless a stalled result holds back a last one;
// the input register takes a character and the result register holds its
// result, captured as the last character leaves the input register.
// Synchronous active-high reset clears the parse state and binary_flag.
// A stalled result holds back only a last character; other characters
// keep flowing while the result waits.
`include "ascii_integer_parser_macros.svh"

module ascii_integer_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic [0:0]  rsp_tuser,   // [0] ok
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_data     // [0] binary_flag
);

   aip_pkg::item_type    req_item;
   aip_pkg::issue_type   issue;
   aip_pkg::res_msg_type res_msg;
   aip_pkg::result_type  rsp_res;
   logic                 out_free;
   logic                 fail_nonzero;
   logic                 last_issued;
   logic                 rsp_stalled;

   assign req_item.character = req_tdata;
   assign req_item.last_char = req_tlast;
   assign csr_ready          = 1'b1;

   aip_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .out_free   (out_free),
      .issue      (issue)
   );

   aip_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .issue     (issue),
      .res_msg   (res_msg)
   );

   aip_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_msg    (res_msg),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata    = rsp_res.value;
   assign rsp_tuser[0] = rsp_res.ok;

   // Checks
   assign fail_nonzero = rsp_tvalid && !rsp_tuser[0] && (rsp_tdata != 64'd0);
   assign last_issued  = issue.fire && issue.item.last_char;
   assign rsp_stalled  = rsp_tvalid && !rsp_tready;

   `AIP_ASSERT(a_fail_zero, clock, reset, !fail_nonzero, "failed result with nonzero value")
   `AIP_ASSERT_NEXT(a_last_result, clock, reset, last_issued, rsp_tvalid, "last item lost")
   `AIP_ASSERT(a_last_held, clock, reset, !(last_issued && rsp_stalled), "issue over stalled result")

endmodule
